>>> hw/rtl/cfe_pkg.sv
// Package for the CRC-16 framed message encoder: payload types, command
// type, sizing constants and the byte-wise CRC-16-CCITT update.
// No dependencies.
package cfe_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned LenW       = 11;
  localparam int unsigned HdrBytes   = 14;
  localparam int unsigned CrcBytes   = 2;
  localparam int unsigned StepW      = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic {
    ModeHeader  = 1'b0,
    ModePayload = 1'b1
  } mode_e;

  typedef struct packed {
    logic            mode;
    logic [15:0]     msg_type;
    logic [31:0]     sender_id;
    logic [31:0]     sequence_req;
    logic [LenW-1:0] payload_len;
    logic [7:0]      data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_item_t;

  // One queued command: a header or one payload byte. last means the CRC
  // follows right after this command's bytes.
  typedef struct packed {
    logic            is_hdr;
    logic            last;
    logic [7:0]      data_byte;
    logic [15:0]     msg_type;
    logic [31:0]     sender_id;
    logic [31:0]     sequence_req;
    logic [LenW-1:0] total_len;
  } cmd_t;

  // MSB-first CRC-16 update over one byte, no reflection.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cfe_front.sv
// Front end: accepts input transactions, tracks the open frame and turns
// each item into a queued command or drops it. Depends on cfe_pkg.
module cfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfe_pkg::in_item_t in_i,
  input  logic            full_i,
  output logic            push_o,
  output cfe_pkg::cmd_t   cmd_o
);
  import cfe_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic [LenW-1:0] len_sat;
  logic            is_hdr;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_hdr     = (in_i.mode == ModeHeader);
  assign len_sat    = (in_i.payload_len > LenW'(MaxPayload)) ? LenW'(MaxPayload)
                                                            : in_i.payload_len;

  always_comb begin
    cmd_o.is_hdr       = is_hdr;
    cmd_o.last         = is_hdr ? (len_sat == '0) : (bytes_left_q == LenW'(1));
    cmd_o.data_byte    = in_i.data_byte;
    cmd_o.msg_type     = in_i.msg_type;
    cmd_o.sender_id    = in_i.sender_id;
    cmd_o.sequence_req = in_i.sequence_req;
    cmd_o.total_len    = LenW'(HdrBytes + CrcBytes) + len_sat;
  end

  // stray payload bytes outside a frame are swallowed here
  assign push_o = accept && (is_hdr || in_frame_q);

  always_comb begin
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    if (accept) begin
      if (is_hdr) begin
        in_frame_d   = (len_sat != '0);
        bytes_left_d = len_sat;
      end else if (in_frame_q) begin
        bytes_left_d = bytes_left_q - LenW'(1);
        in_frame_d   = (bytes_left_q != LenW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

>>> hw/rtl/cfe_queue.sv
// Small command FIFO between the front and back ends.
// Depends on cfe_pkg.
module cfe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfe_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output cfe_pkg::cmd_t head_o,
  input  logic          pop_i
);
  import cfe_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign full_o       = (count_q == (QPtrW + 1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPtrW + 1)'(1);
        2'b01:   count_q <= count_q - (QPtrW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/cfe_back.sv
// Back end: walks the head command byte by byte, runs the CRC and drives
// the registered output stage. Depends on cfe_pkg.
module cfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  cfe_pkg::cmd_t      head_i,
  output logic               pop_o,
  input  logic [15:0]        magic_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfe_pkg::out_item_t out_o
);
  import cfe_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic [15:0]      crc_q, crc_d, crc_base;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             out_free, fire;
  logic [StepW-1:0] n_body, last_step;
  logic             is_body, is_crc_lo, is_crc_hi;
  logic [7:0]       hdr_byte, body_byte, sel_byte;
  logic [15:0]      total16;

  assign out_free  = !out_valid_q || out_ready_i;
  assign fire      = head_valid_i && out_free;
  assign n_body    = head_i.is_hdr ? StepW'(HdrBytes) : StepW'(1);
  assign is_body   = (step_q < n_body);
  assign is_crc_lo = (step_q == n_body);
  assign is_crc_hi = (step_q == n_body + StepW'(1));
  assign last_step = head_i.last ? (n_body + StepW'(1)) : (n_body - StepW'(1));
  assign pop_o     = fire && (step_q == last_step);
  assign total16   = 16'(head_i.total_len);

  // header layout, all fields low byte first
  always_comb begin
    unique case (step_q)
      4'd0:    hdr_byte = magic_word_i[7:0];
      4'd1:    hdr_byte = magic_word_i[15:8];
      4'd2:    hdr_byte = total16[7:0];
      4'd3:    hdr_byte = total16[15:8];
      4'd4:    hdr_byte = head_i.msg_type[7:0];
      4'd5:    hdr_byte = head_i.msg_type[15:8];
      4'd6:    hdr_byte = head_i.sender_id[7:0];
      4'd7:    hdr_byte = head_i.sender_id[15:8];
      4'd8:    hdr_byte = head_i.sender_id[23:16];
      4'd9:    hdr_byte = head_i.sender_id[31:24];
      4'd10:   hdr_byte = head_i.sequence_req[7:0];
      4'd11:   hdr_byte = head_i.sequence_req[15:8];
      4'd12:   hdr_byte = head_i.sequence_req[23:16];
      4'd13:   hdr_byte = head_i.sequence_req[31:24];
      default: hdr_byte = '0;
    endcase
  end

  assign body_byte = head_i.is_hdr ? hdr_byte : head_i.data_byte;
  assign sel_byte  = is_crc_lo ? crc_q[7:0] : (is_crc_hi ? crc_q[15:8] : body_byte);
  // a header always restarts the checksum
  assign crc_base  = (head_i.is_hdr && step_q == '0) ? CrcInit : crc_q;

  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire) begin
      step_d           = pop_o ? '0 : step_q + StepW'(1);
      out_valid_d      = 1'b1;
      out_d.out_byte   = sel_byte;
      out_d.frame_last = is_crc_hi;
      if (is_body) begin
        crc_d = crc_byte(crc_base, body_byte);
      end else if (is_crc_hi) begin
        crc_d = CrcInit;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> hw/rtl/crc16_frame_encoder.sv
// CRC-16 framed message encoder, top level. Uses cfe_pkg, cfe_front,
// cfe_queue and cfe_back.
// Input items are queued; the back-end sequencer registers their bytes out.
// It sends one byte per cycle while a command waits and the output is not stalled;
// a payload byte yields 1 byte (3 with CRC), a header 14 bytes (16 if empty).
// Reset clears frame state, command queue, CRC and output valid; magic word reads 0.
module crc16_frame_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfe_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfe_pkg::out_item_t out_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_magic_word_i
);
  import cfe_pkg::*;

  logic [15:0] magic_word_q;
  logic        push, full, head_valid, pop;
  cmd_t        cmd, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= '0;
    end else if (cfg_we_i) begin
      magic_word_q <= cfg_magic_word_i;
    end
  end

  cfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  cfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  cfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .magic_word_i (magic_word_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

>>> hw/rtl/cfe_checker.sv
// Port-level checker for the framed message encoder, bound to the top level.
// Depends on cfe_pkg and crc16_frame_encoder.
module cfe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cfe_pkg::out_item_t out_o,
  input logic               cfg_we_i,
  input logic [15:0]        cfg_magic_word_i
);
  import cfe_pkg::*;

  logic [15:0] magic_q;
  logic        after_last_q;
  logic        out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  // shadow of the magic word and of frame boundaries seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q      <= '0;
      after_last_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        magic_q <= cfg_magic_word_i;
      end
      if (out_acc) begin
        after_last_q <= out_o.frame_last;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output transaction changed while stalled");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && after_last_q |-> out_o.out_byte == magic_q[7:0])
    else $error("frame does not start with the magic word");

  a_no_short_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && after_last_q |-> !out_o.frame_last)
    else $error("frame end right after a frame end");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind crc16_frame_encoder cfe_checker u_cfe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_o            (out_o),
  .cfg_we_i         (cfg_we_i),
  .cfg_magic_word_i (cfg_magic_word_i)
);
